>>> rtl/assert_macros.svh
// Assertion macros shared by the checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Check that cond implies prop in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/dsc_pkg.sv
// Types and constants of the debounced sequence checker
package dsc_pkg;

    localparam int LANES        = 3;
    localparam int LANE_WIDTH   = 4;
    localparam int MAX_SEQUENCE = 16;
    localparam int ENTRY_BITS   = 4;
    localparam int POS_BITS     = $clog2(MAX_SEQUENCE);
    localparam int SAMPLE_WIDTH = LANES * LANE_WIDTH;
    localparam int SEQ_WIDTH    = MAX_SEQUENCE * ENTRY_BITS;
    localparam int COUNT_WIDTH  = 8;
    localparam int LEN_WIDTH    = 5;
    localparam int CFG_WIDTH    = SEQ_WIDTH;
    localparam int INDEX_WIDTH  = 2;

    // Configuration register indexes
    localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE_LIMIT    = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_EXPECTED_SEQUENCE = 2'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_SEQUENCE_LENGTH   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = 8'd4;
    localparam logic [SEQ_WIDTH-1:0]   SEQUENCE_RESET = 64'h0FED_CBA9_8765_4321;
    localparam logic [LEN_WIDTH-1:0]   LENGTH_RESET   = 5'd16;

    typedef logic [MAX_SEQUENCE-1:0][ENTRY_BITS-1:0] seq_t;

    // Settings shared by all lanes
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] debounce_limit;
        seq_t                   expected;
        logic [POS_BITS-1:0]    last_index;
    } cfg_t;

    // What one lane reports for one item
    typedef struct packed {
        logic                done;
        logic [POS_BITS-1:0] position;
    } lane_result_t;

endpackage

>>> rtl/dsc_lane.sv
// One lane: debounce of a switch code and sequence tracking
`include "assert_macros.svh"

module dsc_lane
    import dsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [LANE_WIDTH-1:0] code,
    input  cfg_t                  cfg,
    output lane_result_t          result
);

    logic [LANE_WIDTH-1:0]  last_code_reg, last_code_next;
    logic                   last_valid_reg, last_valid_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic                   finished_reg, finished_next;
    logic [ENTRY_BITS-1:0]  entry;

    // Pick the expected entry at the current position
    assign entry = cfg.expected[pos_reg];

    // Debounce the code and advance on a stable match
    always_comb
    begin
        last_code_next  = last_code_reg;
        last_valid_next = last_valid_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        finished_next   = finished_reg;
        if (accept && !finished_reg)
        begin
            if (!last_valid_reg || (last_code_reg != code))
            begin
                last_code_next  = code;
                last_valid_next = 1'b1;
                count_next      = '0;
            end
            else if (count_reg < cfg.debounce_limit)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = '0;
                if (code == entry)
                begin
                    if (pos_reg >= cfg.last_index)
                        finished_next = 1'b1;
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    // Report the state as it stands after this item
    assign result.done     = finished_next;
    assign result.position = finished_next ? '0 : pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg  <= '0;
            last_valid_reg <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= '0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            last_code_reg  <= last_code_next;
            last_valid_reg <= last_valid_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            finished_reg   <= finished_next;
        end
    end

    // A finished lane stays frozen
    `ASSERT_NEXT(a_frozen, clk, rst_n, finished_reg, finished_reg && $stable(pos_reg))
    // Without a prior code nothing has been counted or finished
    `ASSERT_SAME(a_no_prior, clk, rst_n, !last_valid_reg, (count_reg == '0) && !finished_reg)

endmodule

>>> rtl/dsc_merge.sv
// Merge of the lane results and two-entry output buffer
`include "assert_macros.svh"

module dsc_merge
    import dsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  lane_result_t [LANES-1:0] lane_result,
    output logic                     full,
    output logic                     out_valid,
    input  logic                     out_stall,
    output lane_result_t [LANES-1:0] out_result,
    output logic                     out_all_done
);

    typedef struct packed {
        lane_result_t [LANES-1:0] lanes;
        logic                     all_done;
    } item_t;

    item_t new_item;
    item_t out_item_reg;
    item_t skid_item_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    logic  take;
    logic  [LANES-1:0] done_bits;

    // Combine the done flags of all lanes
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            done_bits[i] = lane_result[i].done;
    end

    assign new_item.lanes    = lane_result;
    assign new_item.all_done = &done_bits;

    assign take = out_valid_reg && !out_stall;

    // Hold a second item while the first one waits downstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    // Move payloads into the output and skid registers
    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
            out_item_reg <= skid_item_reg;
        else if (accept && (take || !out_valid_reg))
            out_item_reg <= new_item;
        if (accept && out_valid_reg && !take)
            skid_item_reg <= new_item;
    end

    assign full         = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_result   = out_item_reg.lanes;
    assign out_all_done = out_item_reg.all_done;

    // The skid entry is only used behind a waiting output
    `ASSERT_SAME(a_skid_behind, clk, rst_n, skid_valid_reg, out_valid_reg)
    // An item that meets a waiting output lands in the skid entry
    `ASSERT_NEXT(a_skid_fill, clk, rst_n, accept && out_valid_reg && out_stall, skid_valid_reg)

endmodule

>>> rtl/debounced_sequence_checker.sv
// Top level of the debounced sequence checker
//
// Takes one 12-bit sample of three 4-bit switch codes per cycle while in_stall is
// low and gives one result per sample, registered in the output buffer. Each lane
// debounces its code by updating its own registers and, once the code is
// stable, compares it with its next entry of the expected sequence; the merge
// stage ANDs the done flags. A two-entry output buffer lets a new sample be
// taken while one result waits on out_stall; in_stall rises only when both
// entries are full. No clearing pass after reset is needed. The user must write
// configuration only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module debounced_sequence_checker
    import dsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] switch_sample,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [POS_BITS-1:0]     lane0_position,
    output logic                    lane0_done,
    output logic [POS_BITS-1:0]     lane1_position,
    output logic                    lane1_done,
    output logic [POS_BITS-1:0]     lane2_position,
    output logic                    lane2_done,
    output logic                    all_done
);

    logic [COUNT_WIDTH-1:0]   debounce_limit_reg;
    logic [SEQ_WIDTH-1:0]     expected_reg;
    logic [LEN_WIDTH-1:0]     length_reg;
    logic [LEN_WIDTH-1:0]     length_m1;
    logic [POS_BITS-1:0]      last_index;
    logic                     accept;
    logic                     full;
    cfg_t                     cfg;
    lane_result_t [LANES-1:0] lane_result;
    lane_result_t [LANES-1:0] out_result;

    // Write the configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= DEBOUNCE_RESET;
            expected_reg       <= SEQUENCE_RESET;
            length_reg         <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_LIMIT:    debounce_limit_reg <= cfg_data[COUNT_WIDTH-1:0];
                REG_EXPECTED_SEQUENCE: expected_reg       <= cfg_data[SEQ_WIDTH-1:0];
                REG_SEQUENCE_LENGTH:   length_reg         <= cfg_data[LEN_WIDTH-1:0];
                default:               ;
            endcase
        end
    end

    // Clamp the length to one..MAX_SEQUENCE and turn it into a last index
    assign length_m1 = length_reg - 1'b1;
    always_comb
    begin
        priority if (length_reg == '0)
            last_index = '0;
        else if (length_reg > LEN_WIDTH'(MAX_SEQUENCE))
            last_index = POS_BITS'(MAX_SEQUENCE - 1);
        else
            last_index = length_m1[POS_BITS-1:0];
    end

    assign cfg.debounce_limit = debounce_limit_reg;
    assign cfg.expected       = seq_t'(expected_reg);
    assign cfg.last_index     = last_index;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // One core per switch code
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        dsc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .code   (switch_sample[g*LANE_WIDTH +: LANE_WIDTH]),
            .cfg    (cfg),
            .result (lane_result[g])
        );
    end

    dsc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .lane_result  (lane_result),
        .full         (full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result),
        .out_all_done (all_done)
    );

    assign lane0_position = out_result[0].position;
    assign lane0_done     = out_result[0].done;
    assign lane1_position = out_result[1].position;
    assign lane1_done     = out_result[1].done;
    assign lane2_position = out_result[2].position;
    assign lane2_done     = out_result[2].done;

    // A zero length gives a last index of zero
    `ASSERT_SAME(a_last_index, clk, rst_n, 1'b1, (length_reg == '0) ? (last_index == '0) : 1'b1)

endmodule

>>> bench/dsc_progress_monitor.sv
// Monitor that predicts lane progress of the sequence checker and compares every result
`timescale 1ns / 1ps

module dsc_progress_monitor
    import dsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] switch_sample,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [POS_BITS-1:0]     lane0_position,
    input  logic                    lane0_done,
    input  logic [POS_BITS-1:0]     lane1_position,
    input  logic                    lane1_done,
    input  logic [POS_BITS-1:0]     lane2_position,
    input  logic                    lane2_done,
    input  logic                    all_done,
    output int                      mismatches,
    output int                      pending,
    output int                      checked
);

    // One result: every lane's report plus the combined done flag
    typedef struct packed {
        lane_result_t [LANES-1:0] lane;
        logic                     all_done;
    } progress_t;

    // Shadow of the configuration registers
    logic [COUNT_WIDTH-1:0] hold_limit;
    seq_t                   code_table;
    logic [LEN_WIDTH-1:0]   length_setting;

    // Per-lane debounce and sequence state
    logic [LANE_WIDTH-1:0]  prev_code    [LANES];
    logic                   prev_seen    [LANES];
    logic [COUNT_WIDTH-1:0] repeat_count [LANES];
    logic [POS_BITS-1:0]    next_index   [LANES];
    logic                   finished     [LANES];

    progress_t progress_due [$];
    progress_t observed;

    assign observed.lane[0].position = lane0_position;
    assign observed.lane[0].done     = lane0_done;
    assign observed.lane[1].position = lane1_position;
    assign observed.lane[1].done     = lane1_done;
    assign observed.lane[2].position = lane2_position;
    assign observed.lane[2].done     = lane2_done;
    assign observed.all_done         = all_done;

    // Length in force: zero acts as one, anything past the table acts as its size
    function automatic int active_length();
        if (length_setting == '0)
            return 1;
        if (int'(length_setting) > MAX_SEQUENCE)
            return MAX_SEQUENCE;
        return int'(length_setting);
    endfunction

    // Advance every lane by one sample and build the result it reports
    task automatic take_sample(input logic [SAMPLE_WIDTH-1:0] sample, output progress_t rep);
        logic [LANE_WIDTH-1:0] code;
        int                    i;
        rep.all_done = 1'b1;
        for (i = 0; i < LANES; i++)
        begin
            code = sample[i*LANE_WIDTH +: LANE_WIDTH];
            if (!finished[i])
            begin
                if (!prev_seen[i] || prev_code[i] != code)
                begin
                    // new code or first sample: restart the debounce
                    prev_code[i]    = code;
                    prev_seen[i]    = 1'b1;
                    repeat_count[i] = '0;
                end
                else if (repeat_count[i] < hold_limit)
                begin
                    repeat_count[i] = repeat_count[i] + 1'b1;
                end
                else
                begin
                    // stable: compare with the lane's next entry
                    repeat_count[i] = '0;
                    if (code == code_table[next_index[i]])
                    begin
                        if (int'(next_index[i]) + 1 < active_length())
                            next_index[i] = next_index[i] + 1'b1;
                        else
                            finished[i] = 1'b1;
                    end
                end
            end
            rep.lane[i].done     = finished[i];
            rep.lane[i].position = finished[i] ? '0 : next_index[i];
            if (!finished[i])
                rep.all_done = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        progress_t want;
        progress_t fresh;
        int        i;
        if (!rst_n)
        begin
            hold_limit     = DEBOUNCE_RESET;
            code_table     = SEQUENCE_RESET;
            length_setting = LENGTH_RESET;
            for (i = 0; i < LANES; i++)
            begin
                prev_code[i]    = '0;
                prev_seen[i]    = 1'b0;
                repeat_count[i] = '0;
                next_index[i]   = '0;
                finished[i]     = 1'b0;
            end
            progress_due.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            // Track register writes; unknown indexes leave everything alone
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DEBOUNCE_LIMIT:    hold_limit     = cfg_data[COUNT_WIDTH-1:0];
                    REG_EXPECTED_SEQUENCE: code_table     = seq_t'(cfg_data[SEQ_WIDTH-1:0]);
                    REG_SEQUENCE_LENGTH:   length_setting = cfg_data[LEN_WIDTH-1:0];
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (progress_due.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = progress_due.pop_front();
                    checked++;
                    for (i = 0; i < LANES; i++)
                    begin
                        if (observed.lane[i].position !== want.lane[i].position)
                        begin
                            $error("lane%0d_position: expected %0d, got %0d", i,
                                   want.lane[i].position, observed.lane[i].position);
                            mismatches++;
                        end
                        if (observed.lane[i].done !== want.lane[i].done)
                        begin
                            $error("lane%0d_done: expected %0d, got %0d", i,
                                   want.lane[i].done, observed.lane[i].done);
                            mismatches++;
                        end
                    end
                    if (observed.all_done !== want.all_done)
                    begin
                        $error("all_done: expected %0d, got %0d",
                               want.all_done, observed.all_done);
                        mismatches++;
                    end
                end
            end

            // Predict the result of an accepted item
            if (in_valid && !in_stall)
            begin
                take_sample(switch_sample, fresh);
                progress_due.push_back(fresh);
            end
        end
        pending = progress_due.size();
    end

endmodule

>>> bench/tb_debounced_sequence_checker.sv
// Stimulus and verdict for the debounced sequence checker
`timescale 1ns / 1ps

module tb_debounced_sequence_checker;
    import dsc_pkg::*;

    // Index past the register list; writes there must be ignored
    localparam logic [INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

    typedef enum int {PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_write;
    logic [INDEX_WIDTH-1:0]  cfg_index;
    logic [CFG_WIDTH-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [SAMPLE_WIDTH-1:0] switch_sample;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [POS_BITS-1:0]     lane0_position;
    logic                    lane0_done;
    logic [POS_BITS-1:0]     lane1_position;
    logic                    lane1_done;
    logic [POS_BITS-1:0]     lane2_position;
    logic                    lane2_done;
    logic                    all_done;

    int mismatches;
    int pending;
    int checked;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   sent      = 0;
    int   settings  = 0;
    int   hold_setting;
    seq_t code_copy;

    // Last reported lane progress, used to steer the codes toward the next entry
    logic [POS_BITS-1:0] seen_pos  [LANES] = '{default: '0};
    logic                seen_done [LANES] = '{default: 1'b0};

    debounced_sequence_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .switch_sample  (switch_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lane0_position (lane0_position),
        .lane0_done     (lane0_done),
        .lane1_position (lane1_position),
        .lane1_done     (lane1_done),
        .lane2_position (lane2_position),
        .lane2_done     (lane2_done),
        .all_done       (all_done)
    );

    dsc_progress_monitor u_progress (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .switch_sample  (switch_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lane0_position (lane0_position),
        .lane0_done     (lane0_done),
        .lane1_position (lane1_position),
        .lane1_done     (lane1_done),
        .lane2_position (lane2_position),
        .lane2_done     (lane2_done),
        .all_done       (all_done),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Record reported progress
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            seen_pos[0]  <= lane0_position;
            seen_done[0] <= lane0_done;
            seen_pos[1]  <= lane1_position;
            seen_done[1] <= lane1_done;
            seen_pos[2]  <= lane2_position;
            seen_done[2] <= lane2_done;
        end
    end

    task automatic set_pace(input pace_t pace);
        unique case (pace)
            PACE_STEADY:         begin idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin idle_pct = 66; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 66; end
            default:             begin idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] sample);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        switch_sample <= sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_repeat(input logic [SAMPLE_WIDTH-1:0] sample, input int count);
        repeat (count)
            send_sample(sample);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        @(negedge clk);
    endtask

    // Write all registers plus the spare index, then release the port
    task automatic program_regs(input int limit, input logic [SEQ_WIDTH-1:0] codes, input int length);
        write_reg(REG_DEBOUNCE_LIMIT, CFG_WIDTH'(limit));
        write_reg(REG_EXPECTED_SEQUENCE, codes);
        write_reg(REG_SEQUENCE_LENGTH, CFG_WIDTH'(length));
        write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_write    <= 1'b0;
        hold_setting = limit;
        code_copy    = seq_t'(codes);
        settings++;
    endtask

    // Random part: per lane, hold a code (the next entry with chance hit_pct, else random) long enough to settle,
    // with some short holds and single-sample glitches mixed in
    task automatic run_phase(input int count, input int hit_pct);
        logic [LANE_WIDTH-1:0]   code [LANES];
        int                      left [LANES];
        logic [SAMPLE_WIDTH-1:0] sample;
        int                      i;
        int                      k;
        for (i = 0; i < LANES; i++)
        begin
            code[i] = '0;
            left[i] = 0;
        end
        for (k = 0; k < count; k++)
        begin
            for (i = 0; i < LANES; i++)
            begin
                if (left[i] <= 0)
                begin
                    if ($urandom_range(99) < hit_pct)
                        code[i] = code_copy[seen_pos[i]];
                    else
                        code[i] = LANE_WIDTH'($urandom_range(15));
                    if ($urandom_range(99) < 85)
                        left[i] = hold_setting + 2 + $urandom_range(2);
                    else
                        left[i] = $urandom_range(hold_setting + 1, 1);
                end
                if ($urandom_range(99) < 3)
                    sample[i*LANE_WIDTH +: LANE_WIDTH] = LANE_WIDTH'($urandom_range(15));
                else
                    sample[i*LANE_WIDTH +: LANE_WIDTH] = code[i];
                left[i]--;
            end
            send_sample(sample);
        end
    endtask

    // Stop a hung run
    initial
    begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int guard;
        int lanes_done;
        int i;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        switch_sample = '0;
        hold_setting  = DEBOUNCE_RESET;
        code_copy     = SEQUENCE_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first sample, field extremes, stable miss, match, broken hold
        set_pace(PACE_STEADY);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_repeat(12'h999, 6);
        send_repeat(12'h111, 6);
        send_repeat(12'h222, 3);
        send_sample(12'h2F2);
        send_repeat(12'h222, 6);

        // Fastest debounce, full length
        drain();
        set_pace(PACE_SENDER_IDLE);
        program_regs(0, {$urandom, $urandom}, MAX_SEQUENCE);
        run_phase(130, 25);

        // Slowest debounce, oversized length
        drain();
        set_pace(PACE_RECEIVER_STALL);
        program_regs(255, {$urandom, $urandom}, 31);
        run_phase(262, 100);

        // All-zero table, length just past the table
        drain();
        set_pace(PACE_BOTH);
        program_regs(3, '0, 17);
        run_phase(130, 30);

        // One code repeated in every entry
        drain();
        set_pace(PACE_STEADY);
        program_regs(1, {MAX_SEQUENCE{4'($urandom_range(15))}}, MAX_SEQUENCE);
        run_phase(100, 50);

        // Zero length acts as one: the next match finishes a lane
        drain();
        set_pace(PACE_SENDER_IDLE);
        program_regs(2, {$urandom, $urandom}, 0);
        run_phase(80, 60);

        // All-ones table, length one; finished lanes stay frozen
        drain();
        set_pace(PACE_BOTH);
        program_regs(0, '1, 1);
        run_phase(20, 50);

        // Wait out the last results, then wait on for stray results
        in_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pending != 0; guard++)
            @(negedge clk);
        repeat (8) @(negedge clk);

        lanes_done = 0;
        for (i = 0; i < LANES; i++)
            if (seen_done[i])
                lanes_done++;
        $display("Sent %0d samples under %0d register settings; %0d results checked.",
                 sent, settings + 1, checked);
        $display("Lanes that reached the end of their sequence: %0d of %0d.",
                 lanes_done, LANES);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
